@@ sv/tcsf_pkg.sv @@
// Package: shared types and constants of the tile colour/Sobel feature block.
package tcsf_pkg;
    localparam int MaxTile = 64;
    localparam int ColW    = $clog2(MaxTile);
    // one channel of a stencil job: top mid bot tl tm ml mm bl bm, 8 bits each
    localparam int ChJobW  = 72;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef struct packed {
        logic [16:0] mean_red;
        logic [16:0] mean_green;
        logic [16:0] mean_blue;
        logic [18:0] grad_red;
        logic [18:0] grad_green;
        logic [18:0] grad_blue;
    } t_feat;

    // stencil job handed from the front to the back; channel 0 is red
    typedef struct packed {
        logic        interior;
        logic        last;
        logic [6:0]  edge_len;
        logic [3*ChJobW-1:0] win;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE, S_SQRT, S_DIVL, S_DIVG, S_OUT
    } t_bstate;
endpackage

@@ sv/tcsf_ram.sv @@
// Generic single-port-write RAM with registered read.
module tcsf_ram #(
    parameter int Width = 24,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

@@ sv/tcsf_front.sv @@
// Front end: line buffers, 3x3 window and tile position; issues stencil jobs.
module tcsf_front import tcsf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_restart,
    input  logic [6:0] i_edge_len,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_pix       i_pix,
    output logic       o_job_valid,
    input  logic       i_job_ready,
    output t_job       o_job
);
    // two-phase: S0 read line buffers, S1 use data and write back
    logic             r_ph;
    t_pix             r_pix;
    logic [ColW-1:0]  r_col, r_row;
    logic [23:0]      r_win [6]; // tl tm ml mm bl bm
    logic [23:0]      older_q, newer_q;
    logic             we;
    logic [23:0]      top, mid, bot;
    logic             col_end, row_end;

    assign o_ready = !r_ph;
    assign top = older_q;
    assign mid = newer_q;
    assign bot = r_pix;
    assign we  = r_ph && i_job_ready;
    assign col_end = ({1'b0, r_col} + 7'd1) >= i_edge_len;
    assign row_end = ({1'b0, r_row} + 7'd1) >= i_edge_len;

    tcsf_ram #(.Width(24), .Depth(MaxTile)) u_older (
        .i_clk, .i_we(we), .i_waddr(r_col), .i_wdata(mid),
        .i_raddr(r_col), .o_rdata(older_q));
    tcsf_ram #(.Width(24), .Depth(MaxTile)) u_newer (
        .i_clk, .i_we(we), .i_waddr(r_col), .i_wdata(bot),
        .i_raddr(r_col), .o_rdata(newer_q));

    always_comb begin
        o_job_valid   = r_ph;
        o_job.interior = (r_row >= ColW'(2)) && (r_col >= ColW'(2));
        o_job.last     = col_end && row_end;
        o_job.edge_len = i_edge_len;
        o_job.win      = '0;
        // red is the top byte of a pixel
        for (int c = 0; c < 3; c++) begin
            o_job.win[c*ChJobW +: ChJobW] = {
                top[(2-c)*8 +: 8], mid[(2-c)*8 +: 8], bot[(2-c)*8 +: 8],
                r_win[0][(2-c)*8 +: 8], r_win[1][(2-c)*8 +: 8],
                r_win[2][(2-c)*8 +: 8], r_win[3][(2-c)*8 +: 8],
                r_win[4][(2-c)*8 +: 8], r_win[5][(2-c)*8 +: 8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_ph  <= 1'b0;
            r_col <= '0;
            r_row <= '0;
            if (!i_rst_n) for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else if (!r_ph) begin
            if (i_valid) begin
                r_ph  <= 1'b1;
                r_pix <= i_pix;
            end
        end else if (i_job_ready) begin
            r_ph     <= 1'b0;
            r_win[0] <= r_win[1]; r_win[1] <= top;
            r_win[2] <= r_win[3]; r_win[3] <= mid;
            r_win[4] <= r_win[5]; r_win[5] <= bot;
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + ColW'(1);
            end else begin
                r_col <= r_col + ColW'(1);
            end
        end
    end
endmodule

@@ sv/tcsf_fifo.sv @@
// Short job queue between front and back.
module tcsf_fifo import tcsf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_flush,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_data
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
        if (!i_rst_n || i_flush) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ sv/tcsf_back.sv @@
// Back end: Sobel magnitude, accumulation and final division.
module tcsf_back import tcsf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_restart,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_job  i_job,
    output logic  o_valid,
    input  logic  i_ready,
    output t_feat o_feat
);
    t_bstate      r_st, n_st;
    t_job         r_job;
    logic [19:0]  r_lsum [3];
    logic [31:0]  r_gsum [3];
    logic [1:0]   r_ch;
    // sqrt of (sq<<16): 38-bit radicand, 19-bit root, one bit per cycle
    logic [37:0]  r_rad;
    logic [20:0]  r_rem;
    logic [18:0]  r_root;
    logic [4:0]   r_cnt;
    // restoring divider: 40-bit dividend / 24-bit denominator
    logic [39:0]  r_quo;
    logic [24:0]  r_drem;
    logic [5:0]   r_dcnt;
    logic [23:0]  r_den;
    t_feat        r_feat;

    logic signed [10:0] gx, gy;
    logic signed [21:0] gxx, gyy;
    logic [20:0]  sq;
    logic [20:0]  trial;
    logic [22:0]  rem2;
    logic [24:0]  dsh;
    logic [6:0]   ksub;
    logic [7:0]   tp, md, bt, tl, tm, ml, mm, bl, bm;

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_feat  = r_feat;

    always_comb begin
        {tp, md, bt, tl, tm, ml, mm, bl, bm} = r_job.win[r_ch*ChJobW +: ChJobW];
        gx = 11'(signed'({3'b0, tp})) - 11'(signed'({3'b0, tl}))
           + 11'(signed'({2'b0, md, 1'b0})) - 11'(signed'({2'b0, ml, 1'b0}))
           + 11'(signed'({3'b0, bt})) - 11'(signed'({3'b0, bl}));
        gy = 11'(signed'({3'b0, tl})) + 11'(signed'({2'b0, tm, 1'b0}))
           + 11'(signed'({3'b0, tp})) - 11'(signed'({3'b0, bl}))
           - 11'(signed'({2'b0, bm, 1'b0})) - 11'(signed'({3'b0, bt}));
        gxx   = 22'(gx);
        gyy   = 22'(gy);
        sq    = 21'(gxx * gxx + gyy * gyy);
        rem2  = {r_rem, r_rad[37:36]};
        trial = {r_root, 2'b01};
        ksub  = r_job.edge_len - 7'd2;
        dsh   = {r_drem[23:0], r_quo[39]};
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_valid) n_st = S_SQRT;
            S_SQRT: if (r_cnt == 5'd19 && r_ch == 2'd2)
                        n_st = r_job.last ? S_DIVL : S_IDLE;
            S_DIVL: if (r_dcnt == 6'd40 && r_ch == 2'd2) n_st = S_DIVG;
            S_DIVG: if (r_dcnt == 6'd40 && r_ch == 2'd2) n_st = S_OUT;
            S_OUT:  if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_st <= S_IDLE;
            for (int c = 0; c < 3; c++) begin r_lsum[c] <= '0; r_gsum[c] <= '0; end
        end else begin
            r_st <= n_st;
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_job <= i_job; r_ch <= '0; r_cnt <= '0;
                end
                S_SQRT: begin
                    if (r_cnt == 5'd0) begin
                        r_rad <= {1'b0, sq, 16'd0}; r_rem <= '0; r_root <= '0;
                        r_cnt <= 5'd1;
                    end else begin
                        r_rad <= {r_rad[35:0], 2'b0};
                        if (rem2 >= 23'(trial)) begin
                            r_rem  <= 21'(rem2 - 23'(trial));
                            r_root <= {r_root[17:0], 1'b1};
                        end else begin
                            r_rem  <= rem2[20:0];
                            r_root <= {r_root[17:0], 1'b0};
                        end
                        if (r_cnt == 5'd19) begin
                            r_cnt <= '0;
                        end else r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'd19) begin
                            if (r_job.interior) begin
                                r_lsum[r_ch] <= r_lsum[r_ch] + 20'(mm);
                                r_gsum[r_ch] <= r_gsum[r_ch] + 32'({r_root[17:0],
                                    (rem2 >= 23'(trial))});
                            end
                            r_ch <= r_ch + 2'd1;
                            if (r_ch == 2'd2) begin
                                r_ch <= '0; r_dcnt <= '0;
                                r_den <= 24'(ksub) * 24'(ksub) * 24'd255;
                            end
                        end
                    end
                end
                S_DIVL, S_DIVG: begin
                    if (r_dcnt == 6'd0) begin
                        r_quo  <= (r_st == S_DIVL) ? {4'd0, r_lsum[r_ch], 16'd0}
                                                   : {r_gsum[r_ch], 8'd0};
                        r_drem <= '0; r_dcnt <= 6'd1;
                    end else begin
                        if (dsh >= {1'b0, r_den}) begin
                            r_drem <= dsh - {1'b0, r_den};
                            r_quo  <= {r_quo[38:0], 1'b1};
                        end else begin
                            r_drem <= dsh;
                            r_quo  <= {r_quo[38:0], 1'b0};
                        end
                        r_dcnt <= (r_dcnt == 6'd40) ? 6'd0 : r_dcnt + 6'd1;
                        if (r_dcnt == 6'd40) begin
                            r_ch <= (r_ch == 2'd2) ? 2'd0 : r_ch + 2'd1;
                            if (r_st == S_DIVL) begin
                                case (r_ch)
                                    2'd0: r_feat.mean_red   <= {r_quo[15:0], dsh >= {1'b0, r_den}};
                                    2'd1: r_feat.mean_green <= {r_quo[15:0], dsh >= {1'b0, r_den}};
                                    default: r_feat.mean_blue <= {r_quo[15:0], dsh >= {1'b0, r_den}};
                                endcase
                            end else begin
                                case (r_ch)
                                    2'd0: r_feat.grad_red   <= {r_quo[17:0], dsh >= {1'b0, r_den}};
                                    2'd1: r_feat.grad_green <= {r_quo[17:0], dsh >= {1'b0, r_den}};
                                    default: r_feat.grad_blue <= {r_quo[17:0], dsh >= {1'b0, r_den}};
                                endcase
                            end
                        end
                    end
                end
                S_OUT: if (i_ready) begin
                    for (int c = 0; c < 3; c++) begin r_lsum[c] <= '0; r_gsum[c] <= '0; end
                end
                default: ;
            endcase
        end
    end
endmodule

@@ sv/tile_color_sobel_features_core.sv @@
// Top level: tile colour and Sobel gradient feature extractor.
// Pixels of a square tile (edge set by cfg, clamped to 3..64) enter in raster
// order. The front takes a new pixel only once the last one has been handed on
// as a job, as it reads and rewrites two 64-entry line buffers per pixel. A
// two-deep queue hands each 3x3 stencil to the back end, which takes one job at
// a time: it takes the job, then per channel runs a load step and a 19-step
// serial square root. The back end therefore sets the sustained rate; the first
// few items of a burst go faster while the queue fills. After the last pixel of
// a tile six serial divisions produce the features, which are held until taken.
// Writing the tile size restarts the tile.
module tile_color_sobel_features_core import tcsf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_pix       i_pix,
    output logic       o_valid,
    input  logic       i_ready,
    output t_feat      o_feat
);
    logic [6:0] r_tile, edge_len;
    logic       fj_valid, fj_ready, bj_valid, bj_ready;
    t_job       fj, bj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tile <= 7'd8;
        else if (i_cfg_we) r_tile <= i_cfg_data;
    end
    assign edge_len = (r_tile < 7'd3) ? 7'd3 : (r_tile > 7'(MaxTile)) ? 7'(MaxTile) : r_tile;

    tcsf_front u_front (
        .i_clk, .i_rst_n, .i_restart(i_cfg_we), .i_edge_len(edge_len),
        .i_valid, .o_ready, .i_pix,
        .o_job_valid(fj_valid), .i_job_ready(fj_ready), .o_job(fj));
    tcsf_fifo u_fifo (
        .i_clk, .i_rst_n, .i_flush(i_cfg_we),
        .i_valid(fj_valid), .o_ready(fj_ready), .i_data(fj),
        .o_valid(bj_valid), .i_ready(bj_ready), .o_data(bj));
    tcsf_back u_back (
        .i_clk, .i_rst_n, .i_restart(i_cfg_we),
        .i_valid(bj_valid), .o_ready(bj_ready), .i_job(bj),
        .o_valid, .i_ready, .o_feat);
endmodule
